@@ sv/active_tile_detector_defines.svh @@
// ----------------------------------------------------------------------------
// active tile detector assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef ACTIVE_TILE_DETECTOR_DEFINES_SVH
`define ACTIVE_TILE_DETECTOR_DEFINES_SVH

// checked on every edge, reset included
`define ATD_ASSERT_CYC(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// checked only outside reset
`define ATD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ sv/atd_pkg.sv @@
// ----------------------------------------------------------------------------
// atd_pkg
// types and constants shared by the active tile detector modules
// ----------------------------------------------------------------------------
package atd_pkg;

  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int SIZE_W  = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE = 2'd2;

  localparam logic [DIM_W-1:0]  GRID_COLS_RST = 13'd256;
  localparam logic [DIM_W-1:0]  GRID_ROWS_RST = 13'd256;
  localparam logic [SIZE_W-1:0] TILE_SIZE_RST = 8'd62;
  localparam logic [DIM_W-1:0]  DIM_MAX       = 13'd4096;

  localparam int MAX_TILES_X_DEF = 64;
  localparam int JOB_DEPTH_DEF   = 4;

  // up to four tiles close at one cell, in this output order
  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = 2;
  localparam logic [SLOT_W-1:0] SLOT_PREV_LEFT = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_PREV_THIS = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_CUR_LEFT  = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_CUR_THIS  = 2'd3;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] slot_vld;
    logic [COORD_W-1:0]   x_this;
    logic [COORD_W-1:0]   x_left;
    logic [COORD_W-1:0]   y_this;
    logic [COORD_W-1:0]   y_prev;
    logic [SIZE_W-1:0]    tsize;
    logic [SIZE_W-1:0]    w_this;
    logic [SIZE_W-1:0]    h_this;
  } job_t;

endpackage

@@ sv/active_tile_detector.sv @@
// ----------------------------------------------------------------------------
// active_tile_detector
// streams cell dynamic flags in raster order and reports active tiles
//
//   channel  direction  handshake         payload
//   in       request    in_push/in_full   in_cell_dynamic
//   out      result     out_pop/out_empty tile start, size, last_of_run
//   cfg      write      cfg_valid/ready   cfg_index, cfg_data
//
// one cell is taken per cycle while the job queue has room
// a cell that closes k active tiles gives k results through the output register,
//   the job queue of JOB_DEPTH entries absorbs those bursts
// results pass from the closing cell through the job queue to the output register
// reset clears all active bits at once, no clearing pass; a config write to
//   cols, rows or tile size restarts the scan at the first cell
// ----------------------------------------------------------------------------
module active_tile_detector import atd_pkg::*; #(
  parameter int MAX_TILES_X = MAX_TILES_X_DEF,
  parameter int JOB_DEPTH   = JOB_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_cell_dynamic,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [COORD_W-1:0]    out_tile_start_x,
  output logic [COORD_W-1:0]    out_tile_start_y,
  output logic [SIZE_W-1:0]     out_tile_width,
  output logic [SIZE_W-1:0]     out_tile_height,
  output logic                  out_last_of_run,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic q_full, job_push, head_vld, head_pop;
  job_t job, head_job;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  atd_front #(
    .MAX_TILES_X (MAX_TILES_X)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_cell_dynamic (in_cell_dynamic),
    .q_full          (q_full),
    .job_push        (job_push),
    .job             (job)
  );

  atd_job_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .full     (q_full),
    .pop      (head_pop),
    .head_vld (head_vld),
    .head_job (head_job)
  );

  atd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_vld         (head_vld),
    .head_job         (head_job),
    .head_pop         (head_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_tile_start_x (out_tile_start_x),
    .out_tile_start_y (out_tile_start_y),
    .out_tile_width   (out_tile_width),
    .out_tile_height  (out_tile_height),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

@@ sv/atd_front.sv @@
// ----------------------------------------------------------------------------
// atd_front
// scan counters, tile active bits and classification of each cell request
// ----------------------------------------------------------------------------
module atd_front import atd_pkg::*; #(
  parameter int MAX_TILES_X = MAX_TILES_X_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  input  logic                  in_cell_dynamic,
  input  logic                  q_full,
  output logic                  job_push,
  output job_t                  job
);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (v > DIM_MAX) res = DIM_MAX;
    return res;
  endfunction

  logic [DIM_W-1:0]   cols_r, cols_nxt, rows_r, rows_nxt;
  logic [SIZE_W-1:0]  tsz_r, tsz_nxt;
  logic [COORD_W-1:0] cell_col_r, cell_col_nxt, cell_row_r, cell_row_nxt;
  logic [SIZE_W-1:0]  col_in_r, col_in_nxt, row_in_r, row_in_nxt;
  logic [COORD_W-1:0] tile_col_r, tile_col_nxt, tile_row_r, tile_row_nxt;
  logic [COORD_W-1:0] x0_r, x0_nxt, y0_r, y0_nxt;
  logic [DIM_W-1:0]   rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic [MAX_TILES_X-1:0] prev_r, prev_nxt, cur_r, cur_nxt, next_r, next_nxt;

  logic                   restart, accept;
  logic [DIM_W-1:0]       c_eff, r_eff, t_ext;
  logic [SIZE_W-1:0]      t, t_m1;
  logic                   col_end, row_end, last_col, last_row;
  logic                   has_left, has_right, has_prev, has_next;
  logic [COORD_W-1:0]     tx_left, tx_right;
  logic [MAX_TILES_X-1:0] hit, sel_left, sel_this, prev_m, cur_m, next_m;

  // configuration decode, any listed register restarts the scan
  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    tsz_nxt  = tsz_r;
    restart  = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_COLS: begin
          cols_nxt = cfg_data;
          restart  = 1'b1;
        end
        CFG_GRID_ROWS: begin
          rows_nxt = cfg_data;
          restart  = 1'b1;
        end
        CFG_TILE_SIZE: begin
          tsz_nxt = cfg_data[SIZE_W-1:0];
          restart = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign accept = in_push && !q_full;
  assign c_eff  = clamp_dim(cols_r);
  assign r_eff  = clamp_dim(rows_r);
  assign t      = (tsz_r == '0) ? SIZE_W'(1) : tsz_r;
  assign t_m1   = t - SIZE_W'(1);
  assign t_ext  = {{(DIM_W-SIZE_W){1'b0}}, t};

  assign col_end  = (col_in_r == t_m1);
  assign row_end  = (row_in_r == t_m1);
  assign last_col = ({1'b0, cell_col_r} + DIM_W'(1)) >= c_eff;
  assign last_row = ({1'b0, cell_row_r} + DIM_W'(1)) >= r_eff;

  // halo reaches the neighbouring tile on the first and last cell of a tile
  assign has_left  = (col_in_r == '0) && (cell_col_r != '0);
  assign has_right = col_end && !last_col;
  assign has_prev  = (row_in_r == '0) && (cell_row_r != '0);
  assign has_next  = row_end && !last_row;

  assign tx_left  = tile_col_r - COORD_W'(1);
  assign tx_right = tile_col_r + COORD_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_TILES_X; i++) begin
      sel_left[i] = (tx_left == COORD_W'(i));
      sel_this[i] = (tile_col_r == COORD_W'(i));
      hit[i]      = (has_left && sel_left[i]) || sel_this[i] ||
                    (has_right && (tx_right == COORD_W'(i)));
    end
  end

  assign prev_m = prev_r | (hit & {MAX_TILES_X{in_cell_dynamic && has_prev}});
  assign cur_m  = cur_r  | (hit & {MAX_TILES_X{in_cell_dynamic}});
  assign next_m = next_r | (hit & {MAX_TILES_X{in_cell_dynamic && has_next}});

  // tiles whose window closes at this cell, read after this cell's mark
  always_comb begin
    job.slot_vld = '0;
    job.slot_vld[SLOT_PREV_LEFT] = has_prev && has_left && (|(prev_m & sel_left));
    job.slot_vld[SLOT_PREV_THIS] = has_prev && last_col && (|(prev_m & sel_this));
    job.slot_vld[SLOT_CUR_LEFT]  = last_row && has_left && (|(cur_m & sel_left));
    job.slot_vld[SLOT_CUR_THIS]  = last_row && last_col && (|(cur_m & sel_this));
    job.x_this = x0_r;
    job.x_left = x0_r - COORD_W'(t);
    job.y_this = y0_r;
    job.y_prev = y0_r - COORD_W'(t);
    job.tsize  = t;
    job.w_this = (rem_x_r < t_ext) ? rem_x_r[SIZE_W-1:0] : t;
    job.h_this = (rem_y_r < t_ext) ? rem_y_r[SIZE_W-1:0] : t;
  end

  assign job_push = accept && (|job.slot_vld);

  always_comb begin
    cell_col_nxt = cell_col_r;
    cell_row_nxt = cell_row_r;
    col_in_nxt   = col_in_r;
    row_in_nxt   = row_in_r;
    tile_col_nxt = tile_col_r;
    tile_row_nxt = tile_row_r;
    x0_nxt       = x0_r;
    y0_nxt       = y0_r;
    rem_x_nxt    = rem_x_r;
    rem_y_nxt    = rem_y_r;
    prev_nxt     = prev_r;
    cur_nxt      = cur_r;
    next_nxt     = next_r;
    if (restart) begin
      cell_col_nxt = '0;
      cell_row_nxt = '0;
      col_in_nxt   = '0;
      row_in_nxt   = '0;
      tile_col_nxt = '0;
      tile_row_nxt = '0;
      x0_nxt       = '0;
      y0_nxt       = '0;
      rem_x_nxt    = clamp_dim(cols_nxt);
      rem_y_nxt    = clamp_dim(rows_nxt);
      prev_nxt     = '0;
      cur_nxt      = '0;
      next_nxt     = '0;
    end else if (accept) begin
      prev_nxt = prev_m;
      cur_nxt  = cur_m;
      next_nxt = next_m;
      if (last_col) begin
        if (last_row) begin
          // end of frame
          cell_col_nxt = '0;
          cell_row_nxt = '0;
          col_in_nxt   = '0;
          row_in_nxt   = '0;
          tile_col_nxt = '0;
          tile_row_nxt = '0;
          x0_nxt       = '0;
          y0_nxt       = '0;
          rem_x_nxt    = c_eff;
          rem_y_nxt    = r_eff;
          prev_nxt     = '0;
          cur_nxt      = '0;
          next_nxt     = '0;
        end else begin
          cell_col_nxt = '0;
          col_in_nxt   = '0;
          tile_col_nxt = '0;
          x0_nxt       = '0;
          rem_x_nxt    = c_eff;
          cell_row_nxt = cell_row_r + COORD_W'(1);
          row_in_nxt   = row_in_r + SIZE_W'(1);
          if (row_end) begin
            // tile rows move up by one
            row_in_nxt   = '0;
            tile_row_nxt = tile_row_r + COORD_W'(1);
            y0_nxt       = cell_row_r + COORD_W'(1);
            rem_y_nxt    = rem_y_r - t_ext;
            prev_nxt     = cur_m;
            cur_nxt      = next_m;
            next_nxt     = '0;
          end
        end
      end else begin
        cell_col_nxt = cell_col_r + COORD_W'(1);
        col_in_nxt   = col_in_r + SIZE_W'(1);
        if (col_end) begin
          col_in_nxt   = '0;
          tile_col_nxt = tile_col_r + COORD_W'(1);
          x0_nxt       = cell_col_r + COORD_W'(1);
          rem_x_nxt    = rem_x_r - t_ext;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r     <= GRID_COLS_RST;
      rows_r     <= GRID_ROWS_RST;
      tsz_r      <= TILE_SIZE_RST;
      cell_col_r <= '0;
      cell_row_r <= '0;
      col_in_r   <= '0;
      row_in_r   <= '0;
      tile_col_r <= '0;
      tile_row_r <= '0;
      x0_r       <= '0;
      y0_r       <= '0;
      rem_x_r    <= GRID_COLS_RST;
      rem_y_r    <= GRID_ROWS_RST;
      prev_r     <= '0;
      cur_r      <= '0;
      next_r     <= '0;
    end else begin
      cols_r     <= cols_nxt;
      rows_r     <= rows_nxt;
      tsz_r      <= tsz_nxt;
      cell_col_r <= cell_col_nxt;
      cell_row_r <= cell_row_nxt;
      col_in_r   <= col_in_nxt;
      row_in_r   <= row_in_nxt;
      tile_col_r <= tile_col_nxt;
      tile_row_r <= tile_row_nxt;
      x0_r       <= x0_nxt;
      y0_r       <= y0_nxt;
      rem_x_r    <= rem_x_nxt;
      rem_y_r    <= rem_y_nxt;
      prev_r     <= prev_nxt;
      cur_r      <= cur_nxt;
      next_r     <= next_nxt;
    end
  end

endmodule

@@ sv/atd_job_queue.sv @@
// ----------------------------------------------------------------------------
// atd_job_queue
// short queue of closed-tile jobs between front and back
// ----------------------------------------------------------------------------
module atd_job_queue import atd_pkg::*; #(
  parameter int DEPTH = JOB_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_vld,
  output job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ sv/atd_back.sv @@
// ----------------------------------------------------------------------------
// atd_back
// expands each job into tile results in the output register, one per cycle while it is free or popped
// ----------------------------------------------------------------------------
module atd_back import atd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_vld,
  input  job_t               head_job,
  output logic               head_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [COORD_W-1:0] out_tile_start_x,
  output logic [COORD_W-1:0] out_tile_start_y,
  output logic [SIZE_W-1:0]  out_tile_width,
  output logic [SIZE_W-1:0]  out_tile_height,
  output logic               out_last_of_run
);

  logic [NUM_SLOTS-1:0] done_r, done_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [COORD_W-1:0]   sx_r, sy_r, sx_sel, sy_sel;
  logic [SIZE_W-1:0]    w_r, h_r, w_sel, h_sel;
  logic                 last_r;

  logic [NUM_SLOTS-1:0] pending, pick_oh, rest;
  logic [SLOT_W-1:0]    pick_idx;
  logic                 can_load, issue, is_last;

  assign pending  = head_vld ? (head_job.slot_vld & ~done_r) : '0;
  assign can_load = !out_vld_r || out_pop;

  // oldest tile row first, then left column first
  always_comb begin
    pick_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) pick_idx = SLOT_W'(i);
    end
  end

  assign pick_oh  = NUM_SLOTS'(1) << pick_idx;
  assign rest     = pending & ~pick_oh;
  assign is_last  = (rest == '0);
  assign issue    = (|pending) && can_load;
  assign head_pop = issue && is_last;

  always_comb begin
    sx_sel = head_job.x_this;
    sy_sel = head_job.y_this;
    w_sel  = head_job.w_this;
    h_sel  = head_job.h_this;
    unique case (pick_idx)
      SLOT_PREV_LEFT: begin
        sx_sel = head_job.x_left;
        sy_sel = head_job.y_prev;
        w_sel  = head_job.tsize;
        h_sel  = head_job.tsize;
      end
      SLOT_PREV_THIS: begin
        sy_sel = head_job.y_prev;
        h_sel  = head_job.tsize;
      end
      SLOT_CUR_LEFT: begin
        sx_sel = head_job.x_left;
        w_sel  = head_job.tsize;
      end
      SLOT_CUR_THIS: ;
    endcase
  end

  always_comb begin
    done_nxt    = done_r;
    out_vld_nxt = out_vld_r;
    if (out_pop) out_vld_nxt = 1'b0;
    if (issue) begin
      out_vld_nxt = 1'b1;
      done_nxt    = is_last ? '0 : (done_r | pick_oh);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      sx_r   <= sx_sel;
      sy_r   <= sy_sel;
      w_r    <= w_sel;
      h_r    <= h_sel;
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      done_r    <= done_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_empty        = !out_vld_r;
  assign out_tile_start_x = sx_r;
  assign out_tile_start_y = sy_r;
  assign out_tile_width   = w_r;
  assign out_tile_height  = h_r;
  assign out_last_of_run  = last_r;

endmodule

@@ sv/atd_checker.sv @@
// ----------------------------------------------------------------------------
// atd_checker
// port-level checks on the active tile detector, bound to the top level
// ----------------------------------------------------------------------------
`include "active_tile_detector_defines.svh"

module atd_checker import atd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic [COORD_W-1:0] out_tile_start_x,
  input logic [COORD_W-1:0] out_tile_start_y,
  input logic [SIZE_W-1:0]  out_tile_width,
  input logic [SIZE_W-1:0]  out_tile_height,
  input logic               out_last_of_run
);

  // nothing waits on the output after reset
  `ATD_ASSERT_CYC(a_empty_after_reset, !rst_n |=> out_empty, "result shown after reset")

  // a stalled result holds
  `ATD_ASSERT_RST(a_stall_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_tile_start_x) && $stable(out_tile_start_y) && $stable(out_tile_width) && $stable(out_tile_height) && $stable(out_last_of_run)), "stalled result changed")

  // the rest of a cell's tiles follow without a gap
  `ATD_ASSERT_RST(a_run_continues, (!out_empty && out_pop && !out_last_of_run) |=> !out_empty, "tile run broken before last")

  // clipped tiles never collapse to nothing
  `ATD_ASSERT_RST(a_size_nonzero, !out_empty |-> (out_tile_width != '0 && out_tile_height != '0), "empty tile size")

endmodule

bind active_tile_detector atd_checker u_atd_checker (.*);

@@ bench/tb_active_tile_detector.sv @@
// ----------------------------------------------------------------------------
// tb_active_tile_detector
// streams cell flags through the active tile detector under several grid and
// tile settings, predicts the tiles each cell closes and checks every result
// in order; a short scripted part comes first, then randomised phases
// ----------------------------------------------------------------------------
module tb_active_tile_detector;
  import atd_pkg::*;

  localparam int CLK_PERIOD        = 10;
  localparam int TIMEOUT_CYCLES    = 400000;
  localparam int DRAIN_CYCLES      = 12;
  localparam int TRACKED_TILE_COLS = MAX_TILES_X_DEF;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic               last_of_run;
  } tile_rec_t;

  typedef enum logic {ROW_CELL, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  dyn;
    logic                  typed;
    tile_rec_t             want;
  } script_row_t;

  localparam tile_rec_t NO_TILE  = '0;
  localparam tile_rec_t UNIT_TILE = '{12'd0, 12'd0, 8'd1, 8'd1, 1'b1};

  localparam int SCRIPT_LEN = 32;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // reset grid, then a write to the spare index must not restart the scan
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b1, 1'b0, NO_TILE},
    '{ROW_WRITE, CFG_SPARE,     13'h1FFF, 1'b0, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b0, 1'b0, NO_TILE},
    // zero everywhere: a one-cell grid with one-cell tiles
    '{ROW_WRITE, CFG_GRID_COLS, 13'd0,    1'b0, 1'b0, NO_TILE},
    '{ROW_WRITE, CFG_GRID_ROWS, 13'd0,    1'b0, 1'b0, NO_TILE},
    '{ROW_WRITE, CFG_TILE_SIZE, 13'd0,    1'b0, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b1, 1'b1, UNIT_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b0, 1'b1, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b1, 1'b1, UNIT_TILE},
    // oversized width and the widest tile
    '{ROW_WRITE, CFG_GRID_COLS, 13'h1FFF, 1'b0, 1'b0, NO_TILE},
    '{ROW_WRITE, CFG_GRID_ROWS, 13'd1,    1'b0, 1'b0, NO_TILE},
    '{ROW_WRITE, CFG_TILE_SIZE, 13'd255,  1'b0, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b1, 1'b0, NO_TILE},
    '{ROW_WRITE, CFG_GRID_COLS, 13'd1,    1'b0, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b1, 1'b1, UNIT_TILE},
    // halo: a dynamic cell at a tile's left edge wakes the tile to its left
    '{ROW_WRITE, CFG_GRID_COLS, 13'd3,    1'b0, 1'b0, NO_TILE},
    '{ROW_WRITE, CFG_GRID_ROWS, 13'd2,    1'b0, 1'b0, NO_TILE},
    '{ROW_WRITE, CFG_TILE_SIZE, 13'd2,    1'b0, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b0, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b0, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b1, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b0, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b0, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b0, 1'b0, NO_TILE},
    // two tile rows close on the final cell
    '{ROW_WRITE, CFG_GRID_COLS, 13'd2,    1'b0, 1'b0, NO_TILE},
    '{ROW_WRITE, CFG_GRID_ROWS, 13'd3,    1'b0, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b1, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b1, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b1, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b1, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b1, 1'b0, NO_TILE},
    '{ROW_CELL,  CFG_GRID_COLS, 13'd0,    1'b1, 1'b0, NO_TILE}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic                  in_cell_dynamic;
  logic                  out_empty;
  logic                  out_pop;
  logic [COORD_W-1:0]    out_tile_start_x;
  logic [COORD_W-1:0]    out_tile_start_y;
  logic [SIZE_W-1:0]     out_tile_width;
  logic [SIZE_W-1:0]     out_tile_height;
  logic                  out_last_of_run;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predicted block state
  logic [DIM_W-1:0]             grid_cols_q;
  logic [DIM_W-1:0]             grid_rows_q;
  logic [SIZE_W-1:0]            tile_size_q;
  int unsigned                  cell_x, cell_y, sub_x, sub_y, tile_x, tile_y;
  logic [TRACKED_TILE_COLS-1:0] act_above, act_here, act_below;

  tile_rec_t   closing_tiles[$];
  tile_rec_t   pending_tiles[$];
  int unsigned mismatch_count = 0;
  int unsigned stall_pct      = 0;
  int unsigned hold_cycles    = 0;

  active_tile_detector DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_cell_dynamic  (in_cell_dynamic),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_tile_start_x (out_tile_start_x),
    .out_tile_start_y (out_tile_start_y),
    .out_tile_width   (out_tile_width),
    .out_tile_height  (out_tile_height),
    .out_last_of_run  (out_last_of_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_MAX) return 32'(DIM_MAX);
    return 32'(v);
  endfunction

  task automatic restart_scan();
    cell_x = 0;
    cell_y = 0;
    sub_x  = 0;
    sub_y  = 0;
    tile_x = 0;
    tile_y = 0;
    act_above = '0;
    act_here  = '0;
    act_below = '0;
  endtask

  task automatic queue_if_active(input logic [TRACKED_TILE_COLS-1:0] bank,
                                 input int unsigned tx, input int unsigned ty,
                                 input int unsigned tsz, input int unsigned cols,
                                 input int unsigned rows);
    int unsigned sx, sy, w, h;
    tile_rec_t   rec;
    if (tx < TRACKED_TILE_COLS) begin
      if (bank[tx]) begin
        sx = tx * tsz;
        sy = ty * tsz;
        w  = (cols - sx < tsz) ? cols - sx : tsz;
        h  = (rows - sy < tsz) ? rows - sy : tsz;
        rec.start_x     = sx[COORD_W-1:0];
        rec.start_y     = sy[COORD_W-1:0];
        rec.width       = w[SIZE_W-1:0];
        rec.height      = h[SIZE_W-1:0];
        rec.last_of_run = 1'b0;
        closing_tiles = {closing_tiles, rec};
      end
    end
  endtask

  // offers one cell request, then works out the tiles it closes
  task automatic stream_cell(input logic dyn, input logic typed, input tile_rec_t want);
    int unsigned                  cols, rows, tsz, c, r, tx, ty;
    bit                           has_left, has_right, has_prev, has_next;
    bit                           last_col, last_row;
    logic [TRACKED_TILE_COLS-1:0] touch;
    tile_rec_t                    rec;
    in_push         <= 1'b1;
    in_cell_dynamic <= dyn;
    do @(posedge clk); while (in_full);

    cols = eff_dim(grid_cols_q);
    rows = eff_dim(grid_rows_q);
    tsz  = (tile_size_q == '0) ? 1 : 32'(tile_size_q);
    c  = cell_x;
    r  = cell_y;
    tx = tile_x;
    ty = tile_y;
    has_left  = (sub_x == 0) && (c > 0);
    has_right = (sub_x == tsz - 1) && (c + 1 < cols);
    has_prev  = (sub_y == 0) && (r > 0);
    has_next  = (sub_y == tsz - 1) && (r + 1 < rows);
    last_col  = (c + 1 >= cols);
    last_row  = (r + 1 >= rows);

    // the cell sits in the halo of its neighbours across tile edges
    touch = '0;
    if (tx < TRACKED_TILE_COLS) touch[tx] = 1'b1;
    if (has_left && tx - 1 < TRACKED_TILE_COLS) touch[tx-1] = 1'b1;
    if (has_right && tx + 1 < TRACKED_TILE_COLS) touch[tx+1] = 1'b1;
    if (dyn) begin
      if (has_prev) act_above |= touch;
      act_here |= touch;
      if (has_next) act_below |= touch;
    end

    closing_tiles.delete();
    if (has_prev && has_left) queue_if_active(act_above, tx - 1, ty - 1, tsz, cols, rows);
    if (has_prev && last_col) queue_if_active(act_above, tx, ty - 1, tsz, cols, rows);
    if (last_row && has_left) queue_if_active(act_here, tx - 1, ty, tsz, cols, rows);
    if (last_row && last_col) queue_if_active(act_here, tx, ty, tsz, cols, rows);
    if (closing_tiles.size() > 0) begin
      rec = closing_tiles.pop_back();
      rec.last_of_run = 1'b1;
      closing_tiles = {closing_tiles, rec};
    end
    if (typed) begin
      closing_tiles.delete();
      if (want != NO_TILE) closing_tiles = {closing_tiles, want};
    end
    foreach (closing_tiles[k]) pending_tiles = {pending_tiles, closing_tiles[k]};

    if (last_col) begin
      if (last_row) begin
        restart_scan();
      end else begin
        cell_x = 0;
        sub_x  = 0;
        tile_x = 0;
        cell_y = r + 1;
        sub_y++;
        if (sub_y >= tsz) begin
          sub_y     = 0;
          tile_y    = (ty + 1) & 32'hFFF;
          act_above = act_here;
          act_here  = act_below;
          act_below = '0;
        end
      end
    end else begin
      cell_x = c + 1;
      sub_x++;
      if (sub_x >= tsz) begin
        sub_x  = 0;
        tile_x = (tx + 1) & 32'hFFF;
      end
    end
  endtask

  // waits until every predicted tile has been taken and the pipe is empty
  task automatic settle();
    do @(posedge clk); while (pending_tiles.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GRID_COLS: begin
        grid_cols_q = val;
        restart_scan();
      end
      CFG_GRID_ROWS: begin
        grid_rows_q = val;
        restart_scan();
      end
      CFG_TILE_SIZE: begin
        tile_size_q = val[SIZE_W-1:0];
        restart_scan();
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned cols, input int unsigned rows,
                           input int unsigned tsz, input int unsigned ncells,
                           input int unsigned dyn_pct, input int unsigned gap_pct,
                           input int unsigned stall, input int unsigned hold,
                           input bit pause_mid);
    in_push <= 1'b0;
    settle();
    write_reg(CFG_GRID_COLS, CFG_DATA_W'(cols));
    write_reg(CFG_GRID_ROWS, CFG_DATA_W'(rows));
    write_reg(CFG_TILE_SIZE, CFG_DATA_W'(tsz));
    stall_pct   = stall;
    hold_cycles = hold;
    for (int i = 0; i < int'(ncells); i++) begin
      if (pause_mid && i == int'(ncells / 2)) begin
        in_push <= 1'b0;
        settle();
      end else begin
        // each idle cycle drawn on its own
        while ($urandom_range(99) < gap_pct) begin
          in_push <= 1'b0;
          @(posedge clk);
        end
      end
      stream_cell($urandom_range(99) < dyn_pct, 1'b0, NO_TILE);
    end
  endtask

  // result side: random stalls, or a long hold-off when asked
  initial begin
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic void check_field(input string what, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    tile_rec_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_tiles.size() == 0) begin
        $display("%0t: tile x=%0d y=%0d arrived with nothing expected",
                 $time, out_tile_start_x, out_tile_start_y);
        mismatch_count++;
      end else begin
        want = pending_tiles.pop_front();
        check_field("tile_start_x", 32'(want.start_x), 32'(out_tile_start_x));
        check_field("tile_start_y", 32'(want.start_y), 32'(out_tile_start_y));
        check_field("tile_width", 32'(want.width), 32'(out_tile_width));
        check_field("tile_height", 32'(want.height), 32'(out_tile_height));
        check_field("last_of_run", 32'(want.last_of_run), 32'(out_last_of_run));
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned cols, rows, tsz;
    rst_n           <= 1'b0;
    in_push         <= 1'b0;
    in_cell_dynamic <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_GRID_COLS;
    cfg_data        <= '0;
    grid_cols_q = GRID_COLS_RST;
    grid_rows_q = GRID_ROWS_RST;
    tile_size_q = TILE_SIZE_RST;
    restart_scan();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (SCRIPT[k]) begin
      if (SCRIPT[k].kind == ROW_WRITE) begin
        in_push <= 1'b0;
        settle();
        write_reg(SCRIPT[k].idx, SCRIPT[k].data);
      end else begin
        stream_cell(SCRIPT[k].dyn, SCRIPT[k].typed, SCRIPT[k].want);
      end
    end

    //        cols rows tile cells dyn% gap% stall% hold pause
    run_phase(5,   5,   2,   50,   35,  0,   0,     0,   1'b0);
    run_phase(7,   5,   3,   35,   15,  71,  0,     0,   1'b1);
    run_phase(4,   7,   1,   28,   40,  0,   71,    0,   1'b0);
    // tile columns past the tracked range
    run_phase(66,  1,   1,   66,   60,  31,  31,    0,   1'b0);
    // dense results against a stalled receiver fill the block
    run_phase(6,   6,   1,   36,   100, 0,   0,     60,  1'b0);
    run_phase(3,   4,   254, 12,   30,  0,   0,     0,   1'b0);
    for (int p = 0; p < 4; p++) begin
      cols = $urandom_range(1, 10);
      rows = $urandom_range(1, 10);
      tsz  = $urandom_range(1, 4);
      run_phase(cols, rows, tsz, $urandom_range(20, 30), $urandom_range(10, 60),
                (p == 1) ? 71 : (p == 3) ? 31 : 0, (p == 2) ? 71 : (p == 3) ? 31 : 0,
                0, 1'b0);
    end

    in_push <= 1'b0;
    settle();
    if (mismatch_count == 0 && pending_tiles.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ active_tile_detector.f @@
+incdir+sv
sv/atd_pkg.sv
sv/atd_front.sv
sv/atd_job_queue.sv
sv/atd_back.sv
sv/active_tile_detector.sv
sv/atd_checker.sv
bench/tb_active_tile_detector.sv
